// ----- hdl/bmp24sd_pkg.sv -----
`default_nettype none

package bmp24sd_pkg;

	// Register width of the max_dimension setting and its value after reset
	localparam int                   CFG_W         = 14;
	localparam logic [CFG_W-1:0]     MAX_DIM_RESET = 14'd10000;

	// Fixed widths of the result fields
	localparam int                   FIELD_COORD_W = 14;

	// Result queue geometry
	localparam int                   Q_DEPTH = 4;
	localparam int                   Q_AW    = 2;
	localparam int                   Q_CW    = 3;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_SIGNATURE   = 4'd1,
		ST_RESERVED    = 4'd2,
		ST_INFO_SIZE   = 4'd3,
		ST_BITCOUNT    = 4'd4,
		ST_COMPRESSION = 4'd5,
		ST_OFFSET      = 4'd6,
		ST_DIMS        = 4'd7,
		ST_FILESIZE    = 4'd8,
		ST_TRUNCATED   = 4'd9
	} status_t;

	typedef enum logic {
		KIND_PIXEL  = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       is_last;
	} in_beat_t;

	typedef struct packed {
		kind_t                    kind;
		logic [7:0]               red;
		logic [7:0]               green;
		logic [7:0]               blue;
		logic [FIELD_COORD_W-1:0] column;
		logic [FIELD_COORD_W-1:0] row;
		status_t                  status;
		logic [FIELD_COORD_W-1:0] image_width;
		logic [FIELD_COORD_W-1:0] image_height;
		logic                     end_of_run;
	} out_beat_t;

	// Results produced by one byte: count (0..2) and the beats in order
	typedef struct packed {
		logic [1:0] n;
		out_beat_t  r0;
		out_beat_t  r1;
	} push_t;

endpackage

`default_nettype wire

// ----- hdl/bmp24sd_core.sv -----
`default_nettype none

module bmp24sd_core #(
	parameter int COORD_WIDTH = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  bmp24sd_pkg::in_beat_t          beat,
	input  logic [bmp24sd_pkg::CFG_W-1:0]  max_dim,
	output bmp24sd_pkg::push_t             push
);
	import bmp24sd_pkg::*;

	localparam int          CW        = COORD_WIDTH;
	localparam int          BW        = COORD_WIDTH + 2;
	localparam logic [31:0] COORD_MAX = 32'((64'd1 << COORD_WIDTH) - 64'd1);
	localparam logic [15:0] SIGNATURE = 16'h4D42;
	localparam logic [31:0] FILE_HDR  = 32'd14;
	localparam logic [15:0] BPP_24    = 16'd24;
	localparam logic [31:0] INFO_CORE = 32'd12;
	localparam logic [31:0] INFO_V1   = 32'd40;
	localparam logic [31:0] INFO_V2   = 32'd52;
	localparam logic [31:0] INFO_V3   = 32'd56;
	localparam logic [31:0] INFO_V4   = 32'd108;
	localparam logic [31:0] OFF_SAT   = 32'hFFFF_FFFF;
	localparam logic [31:0] MIN_COUNT = 32'd6;
	localparam logic [31:0] MIN_HDR   = 32'd26;

	// byte lane of a little-endian field that starts at base
	function automatic logic [1:0] lane_of(input logic [31:0] idx, input logic [1:0] base);
		return idx[1:0] - base;
	endfunction

	function automatic logic dim_bad(input logic [31:0] v, input logic [31:0] lim);
		return (v == 32'd0) || (v > lim);
	endfunction

	function automatic logic info_ok(input logic [31:0] s);
		return (s == INFO_CORE) || (s == INFO_V1) || (s == INFO_V2) ||
			(s == INFO_V3) || (s == INFO_V4);
	endfunction

	logic [31:0]   off_q, off_d;
	logic [15:0]   sig_q, sig_d;
	logic [31:0]   fsize_q, fsize_d;
	logic [31:0]   rsvd_q, rsvd_d;
	logic [31:0]   pdo_q, pdo_d;
	logic [31:0]   info_q, info_d;
	logic [31:0]   width_q, width_d;
	logic [31:0]   height_q, height_d;
	logic [15:0]   bpp_q, bpp_d;
	logic [31:0]   comp_q, comp_d;
	logic [CW-1:0] col_q, col_d;
	logic [CW-1:0] rows_q, rows_d;
	logic [BW-1:0] bir_q, bir_d;
	logic [1:0]    phase_q, phase_d;
	logic [15:0]   pp_q, pp_d;
	status_t       err_q, err_d;

	logic [BW-1:0] w3_q;
	logic [BW-1:0] stride_q;

	logic [31:0]   idx;
	logic [7:0]    b;
	logic [31:0]   lim;
	logic [31:0]   info_new;
	logic [BW-1:0] bir_inc;
	logic          pix;
	status_t       st;
	out_beat_t     pix_beat;
	out_beat_t     st_beat;
	logic [CW-1:0] row_td;

	assign idx = off_q;
	assign b   = beat.byte_value;
	assign lim = ({{(32-CFG_W){1'b0}}, max_dim} > COORD_MAX) ? COORD_MAX :
		{{(32-CFG_W){1'b0}}, max_dim};
	assign info_new = {b, info_q[23:0]};
	assign bir_inc  = bir_q + BW'(1);
	assign row_td   = height_q[CW-1:0] - CW'(1) - rows_q;

	always_comb begin
		off_d    = off_q;
		sig_d    = sig_q;
		fsize_d  = fsize_q;
		rsvd_d   = rsvd_q;
		pdo_d    = pdo_q;
		info_d   = info_q;
		width_d  = width_q;
		height_d = height_q;
		bpp_d    = bpp_q;
		comp_d   = comp_q;
		col_d    = col_q;
		rows_d   = rows_q;
		bir_d    = bir_q;
		phase_d  = phase_q;
		pp_d     = pp_q;
		err_d    = err_q;
		pix      = 1'b0;

		if (err_q == ST_OK) begin
			if (idx < 32'd2) begin
				sig_d[{idx[0], 3'b000} +: 8] = b;
				if (idx == 32'd1 && {b, sig_q[7:0]} != SIGNATURE)
					err_d = ST_SIGNATURE;
			end else if (idx < 32'd6) begin
				fsize_d[{lane_of(idx, 2'd2), 3'b000} +: 8] = b;
			end else if (idx < 32'd10) begin
				rsvd_d[{lane_of(idx, 2'd2), 3'b000} +: 8] = b;
				if (idx == 32'd9 && {b, rsvd_q[23:0]} != 32'd0)
					err_d = ST_RESERVED;
			end else if (idx < 32'd14) begin
				pdo_d[{lane_of(idx, 2'd2), 3'b000} +: 8] = b;
			end else if (idx < 32'd18) begin
				info_d[{lane_of(idx, 2'd2), 3'b000} +: 8] = b;
				if (idx == 32'd17) begin
					if (!info_ok(info_new))
						err_d = ST_INFO_SIZE;
					else if (pdo_q != FILE_HDR + info_new)
						err_d = ST_OFFSET;
				end
			end else if (idx < pdo_q) begin
				if (info_q == INFO_CORE) begin
					// 16-bit core header: width 18, height 20, bit count 24
					if (idx < 32'd20) begin
						width_d[{lane_of(idx, 2'd2), 3'b000} +: 8] = b;
						if (idx == 32'd19 && dim_bad({16'd0, b, width_q[7:0]}, lim))
							err_d = ST_DIMS;
					end else if (idx < 32'd22) begin
						height_d[{lane_of(idx, 2'd0), 3'b000} +: 8] = b;
						if (idx == 32'd21 && dim_bad({16'd0, b, height_q[7:0]}, lim))
							err_d = ST_DIMS;
					end else if (idx >= 32'd24 && idx < 32'd26) begin
						bpp_d[{lane_of(idx, 2'd0) == 2'd1, 3'b000} +: 8] = b;
						if (idx == 32'd25 && {b, bpp_q[7:0]} != BPP_24)
							err_d = ST_BITCOUNT;
					end
				end else begin
					if (idx < 32'd22) begin
						width_d[{lane_of(idx, 2'd2), 3'b000} +: 8] = b;
						if (idx == 32'd21 && dim_bad({b, width_q[23:0]}, lim))
							err_d = ST_DIMS;
					end else if (idx < 32'd26) begin
						height_d[{lane_of(idx, 2'd2), 3'b000} +: 8] = b;
						if (idx == 32'd25 && dim_bad({b, height_q[23:0]}, lim))
							err_d = ST_DIMS;
					end else if (idx >= 32'd28 && idx < 32'd30) begin
						bpp_d[{lane_of(idx, 2'd0) == 2'd1, 3'b000} +: 8] = b;
						if (idx == 32'd29 && {b, bpp_q[7:0]} != BPP_24)
							err_d = ST_BITCOUNT;
					end else if (idx >= 32'd30 && idx < 32'd34) begin
						comp_d[{lane_of(idx, 2'd2), 3'b000} +: 8] = b;
						if (idx == 32'd33 && {b, comp_q[23:0]} != 32'd0)
							err_d = ST_COMPRESSION;
					end
				end
			end else if ({{(32-CW){1'b0}}, rows_q} < height_q) begin
				// pixel rows: B, G, R per pixel, then pad to the stride
				if (bir_q < w3_q) begin
					case (phase_q)
						2'd0: begin
							pp_d    = {8'd0, b};
							phase_d = 2'd1;
						end
						2'd1: begin
							pp_d[15:8] = b;
							phase_d    = 2'd2;
						end
						default: begin
							pix     = 1'b1;
							col_d   = col_q + CW'(1);
							phase_d = 2'd0;
						end
					endcase
				end
				bir_d = bir_inc;
				if (bir_inc >= stride_q) begin
					bir_d   = '0;
					col_d   = '0;
					phase_d = 2'd0;
					rows_d  = rows_q + CW'(1);
				end
			end
		end

		if (off_q != OFF_SAT)
			off_d = off_q + 32'd1;
	end

	// end-of-file status
	always_comb begin
		if (err_d != ST_OK)
			st = err_d;
		else if (off_d < MIN_COUNT)
			st = ST_TRUNCATED;
		else if (fsize_d != off_d)
			st = ST_FILESIZE;
		else if (off_d < MIN_HDR || off_d < pdo_d ||
			{{(32-CW){1'b0}}, rows_d} != height_d)
			st = ST_TRUNCATED;
		else
			st = ST_OK;
	end

	always_comb begin
		pix_beat              = '0;
		pix_beat.kind         = KIND_PIXEL;
		pix_beat.red          = b;
		pix_beat.green        = pp_q[15:8];
		pix_beat.blue         = pp_q[7:0];
		pix_beat.column       = FIELD_COORD_W'(col_q);
		pix_beat.row          = FIELD_COORD_W'(row_td);
		pix_beat.status       = ST_OK;
		pix_beat.end_of_run   = !beat.is_last;

		st_beat               = '0;
		st_beat.kind          = KIND_STATUS;
		st_beat.status        = st;
		st_beat.image_width   = (st == ST_OK) ? width_d[FIELD_COORD_W-1:0] : '0;
		st_beat.image_height  = (st == ST_OK) ? height_d[FIELD_COORD_W-1:0] : '0;
		st_beat.end_of_run    = 1'b1;

		push = '0;
		if (fire) begin
			if (pix) begin
				push.r0 = pix_beat;
				push.r1 = st_beat;
				push.n  = beat.is_last ? 2'd2 : 2'd1;
			end else if (beat.is_last) begin
				push.r0 = st_beat;
				push.n  = 2'd1;
			end
		end
	end

	// row geometry, settled long before the first pixel byte
	always_ff @(posedge clk) begin
		w3_q     <= BW'(width_q[CW-1:0]) + {1'b0, width_q[CW-1:0], 1'b0};
		stride_q <= (w3_q + BW'(3)) & ~BW'(3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= '0;
			sig_q    <= '0;
			fsize_q  <= '0;
			rsvd_q   <= '0;
			pdo_q    <= '0;
			info_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			bpp_q    <= '0;
			comp_q   <= '0;
			col_q    <= '0;
			rows_q   <= '0;
			bir_q    <= '0;
			phase_q  <= '0;
			pp_q     <= '0;
			err_q    <= ST_OK;
		end else if (fire) begin
			if (beat.is_last) begin
				off_q    <= '0;
				sig_q    <= '0;
				fsize_q  <= '0;
				rsvd_q   <= '0;
				pdo_q    <= '0;
				info_q   <= '0;
				width_q  <= '0;
				height_q <= '0;
				bpp_q    <= '0;
				comp_q   <= '0;
				col_q    <= '0;
				rows_q   <= '0;
				bir_q    <= '0;
				phase_q  <= '0;
				pp_q     <= '0;
				err_q    <= ST_OK;
			end else begin
				off_q    <= off_d;
				sig_q    <= sig_d;
				fsize_q  <= fsize_d;
				rsvd_q   <= rsvd_d;
				pdo_q    <= pdo_d;
				info_q   <= info_d;
				width_q  <= width_d;
				height_q <= height_d;
				bpp_q    <= bpp_d;
				comp_q   <= comp_d;
				col_q    <= col_d;
				rows_q   <= rows_d;
				bir_q    <= bir_d;
				phase_q  <= phase_d;
				pp_q     <= pp_d;
				err_q    <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/bmp24sd_outq.sv -----
`default_nettype none

module bmp24sd_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bmp24sd_pkg::push_t     push,
	input  logic                   pop_ready,
	output logic                   valid,
	output bmp24sd_pkg::out_beat_t beat,
	output logic                   room
);
	import bmp24sd_pkg::*;

	out_beat_t       ent_q [Q_DEPTH];
	logic [Q_AW-1:0] head_q;
	logic [Q_AW-1:0] tail_q;
	logic [Q_CW-1:0] count_q;
	logic            pop;

	assign valid = (count_q != '0);
	assign beat  = ent_q[head_q];
	assign pop   = valid && pop_ready;
	// two free slots cover the worst case of one byte
	assign room  = (count_q <= Q_CW'(Q_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			ent_q[tail_q] <= push.r0;
		if (push.n == 2'd2)
			ent_q[tail_q + Q_AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + Q_AW'(push.n);
			if (pop)
				head_q <= head_q + Q_AW'(1);
			count_q <= count_q + Q_CW'(push.n) - Q_CW'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/bmp24_stream_decoder_top.sv -----
`default_nettype none

// Path: input register -> decoder -> four-entry result queue -> result_beat.
// Throughput: one byte per cycle while the queue has room; a byte that ends a pixel
//   and the file gives two beats, drained one per cycle while result_ready is high.
// Reset: arst_n clears the decoder to the start of a new file and sets max_dimension
//   to 10000; the decoder also returns to that start state after each final byte.
module bmp24_stream_decoder_top #(
	parameter int COORD_WIDTH = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// byte stream in
	input  logic                          byte_valid,
	output logic                          byte_ready,
	input  bmp24sd_pkg::in_beat_t         byte_beat,
	// pixel / status stream out
	output logic                          result_valid,
	input  logic                          result_ready,
	output bmp24sd_pkg::out_beat_t        result_beat,
	// max_dimension register
	input  logic                          cfg_wr_en,
	input  logic [bmp24sd_pkg::CFG_W-1:0] cfg_wr_data
);
	import bmp24sd_pkg::*;

	// Input register: holds one beat; it moves into the decoder as soon as the
	// result queue can take the worst case (two beats). Ready never looks at
	// result_ready directly, only at the registered queue fill.
	in_beat_t          beat_s1;
	logic              vld_s1;
	logic              fire;
	logic              room;
	logic [CFG_W-1:0]  max_dim_q;
	push_t             push;

	assign fire       = vld_s1 && room;
	assign byte_ready = !vld_s1 || fire;

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready)
			beat_s1 <= byte_beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	// Config register: the user must write it only while the stream is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dim_q <= MAX_DIM_RESET;
		end else if (cfg_wr_en) begin
			max_dim_q <= cfg_wr_data;
		end
	end

	// Header collection, checks, row walk and status, all in one pass per beat.
	bmp24sd_core #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.beat    (beat_s1),
		.max_dim (max_dim_q),
		.push    (push)
	);

	// Result registers: a small queue so a pixel and a status from one byte
	// both land without stalling the byte side.
	bmp24sd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop_ready (result_ready),
		.valid     (result_valid),
		.beat      (result_beat),
		.room      (room)
	);

endmodule

`default_nettype wire
